/* design/gsa_pkg.sv */
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared widths, operation codes and status codes of the generational slot
// allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

    localparam int OP_W     = 3;
    localparam int SIDX_W   = 8;
    localparam int HGEN_W   = 16;
    localparam int STATE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 9;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_GET     = 3'd2,
        OP_SET     = 3'd3,
        OP_CHECK   = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_STALE = 2'd2
    } t_status;

endpackage

/* design/generational_slot_allocator_top.sv */
// ----------------------------------------------------------------------------
// generational_slot_allocator_top
// Slot table with per-slot generation counters and a LIFO stack of free slot
// indices, both held in synchronous RAMs.
//
//  Channel   Dir  Handshake                 Data
//  request   in   i_valid / o_ready         i_op, i_slot_index,
//                                           i_handle_generation, i_state_value
//  response  out  o_valid / i_ready         o_status, o_out_index,
//                                           o_out_generation, o_out_state,
//                                           o_active_count
//  config    in   i_cfg_valid / o_cfg_ready i_cfg_capacity
//
// A handle operation, and an allocate into a full table, issues the slot read
// in the idle state and decides, and writes back where it writes, in the lookup
// state; a successful allocate reads the free stack in the idle state and the
// slot in the pop state, as the slot read waits for the free-stack read to return.
// Only one request is in flight, which orders all accesses to an entry.
// After reset and after every capacity transfer a clearing pass over every RAM entry runs with o_ready low.
// A result waiting in the output register does not block the next transfer;
// that request then holds in the lookup state until the output is taken.
// ----------------------------------------------------------------------------
module generational_slot_allocator_top #(
    parameter int MAX_SLOTS = 256,
    parameter int GEN_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [gsa_pkg::OP_W-1:0]    i_op,
    input  logic [gsa_pkg::SIDX_W-1:0]  i_slot_index,
    input  logic [gsa_pkg::HGEN_W-1:0]  i_handle_generation,
    input  logic [gsa_pkg::STATE_W-1:0] i_state_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [gsa_pkg::STATUS_W-1:0] o_status,
    output logic [gsa_pkg::SIDX_W-1:0]  o_out_index,
    output logic [gsa_pkg::HGEN_W-1:0]  o_out_generation,
    output logic [gsa_pkg::STATE_W-1:0] o_out_state,
    output logic [gsa_pkg::CAP_W-1:0]   o_active_count,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gsa_pkg::CAP_W-1:0]   i_cfg_capacity
);
    import gsa_pkg::*;

    localparam int CAP_MAX   = (MAX_SLOTS < 511) ? MAX_SLOTS : 511;
    localparam int CAP_RESET = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
    localparam int DEPTH     = CAP_MAX;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int GCMP_W    = (GEN_BITS > HGEN_W) ? GEN_BITS : HGEN_W;
    localparam int SLOT_W    = 1 + GEN_BITS + STATE_W;

    localparam logic [CAP_W-1:0] CAP_MAX_V   = CAP_W'(CAP_MAX);
    localparam logic [CAP_W-1:0] CAP_RESET_V = CAP_W'(CAP_RESET);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_LOOK
    } t_state;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_clr_addr, n_clr_addr;
    logic [CAP_W-1:0]     r_cap, n_cap;
    logic [CAP_W-1:0]     r_top, n_top;
    logic [CAP_W-1:0]     r_used, n_used;
    logic [OP_W-1:0]      r_op, n_op;
    logic [SIDX_W-1:0]    r_idx, n_idx;
    logic [HGEN_W-1:0]    r_gen, n_gen;
    logic [STATE_W-1:0]   r_val, n_val;
    logic [IDX_W-1:0]     r_slot, n_slot;
    logic                 r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;
    logic [SIDX_W-1:0]    r_out_index, n_out_index;
    logic [HGEN_W-1:0]    r_out_gen, n_out_gen;
    logic [STATE_W-1:0]   r_out_state, n_out_state;
    logic [CAP_W-1:0]     r_out_count, n_out_count;

    logic                 slot_we, slot_re;
    logic [IDX_W-1:0]     slot_waddr, slot_raddr;
    logic [SLOT_W-1:0]    slot_wdata, slot_rdata;
    logic                 stk_we, stk_re;
    logic [IDX_W-1:0]     stk_waddr, stk_raddr;
    logic [IDX_W-1:0]     stk_wdata, stk_rdata;

    logic                 rd_in_use;
    logic [GEN_BITS-1:0]  rd_gen, gen_inc, gen_new;
    logic [STATE_W-1:0]   rd_state;
    logic                 handle_ok;
    logic [CAP_W-1:0]     cap_clamped;

    gsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    gsa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign rd_in_use = slot_rdata[SLOT_W-1];
    assign rd_gen    = slot_rdata[STATE_W +: GEN_BITS];
    assign rd_state  = slot_rdata[STATE_W-1:0];
    assign gen_inc   = rd_gen + GEN_BITS'(1);
    assign gen_new   = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

    assign handle_ok = (r_gen != '0) && (CAP_W'(r_idx) < r_cap) && rd_in_use
                       && (GCMP_W'(rd_gen) == GCMP_W'(r_gen));

    always_comb begin
        if (i_cfg_capacity == '0) begin
            cap_clamped = CAP_W'(1);
        end else if (i_cfg_capacity > CAP_MAX_V) begin
            cap_clamped = CAP_MAX_V;
        end else begin
            cap_clamped = i_cfg_capacity;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_cap        = r_cap;
        n_top        = r_top;
        n_used       = r_used;
        n_op         = r_op;
        n_idx        = r_idx;
        n_gen        = r_gen;
        n_val        = r_val;
        n_slot       = r_slot;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        n_out_gen    = r_out_gen;
        n_out_state  = r_out_state;
        n_out_count  = r_out_count;

        slot_we    = 1'b0;
        slot_waddr = r_slot;
        slot_wdata = '0;
        slot_re    = 1'b0;
        slot_raddr = IDX_W'(i_slot_index);
        stk_we     = 1'b0;
        stk_waddr  = IDX_W'(r_top);
        stk_wdata  = r_slot;
        stk_re     = 1'b0;
        stk_raddr  = IDX_W'(r_top - CAP_W'(1));

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr_addr;
                slot_wdata = '0;
                stk_we     = 1'b1;
                stk_waddr  = r_clr_addr;
                stk_wdata  = IDX_W'(r_cap - CAP_W'(1) - CAP_W'(r_clr_addr));
                if (r_clr_addr == IDX_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + IDX_W'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op  = i_op;
                    n_idx = i_slot_index;
                    n_gen = i_handle_generation;
                    n_val = i_state_value;
                    if ((i_op == OP_ALLOC) && (r_top != '0)) begin
                        stk_re  = 1'b1;
                        n_state = S_POP;
                    end else begin
                        slot_re = 1'b1;
                        n_slot  = IDX_W'(i_slot_index);
                        n_state = S_LOOK;
                    end
                end
            end
            S_POP: begin
                slot_re    = 1'b1;
                slot_raddr = stk_rdata;
                n_slot     = stk_rdata;
                n_state    = S_LOOK;
            end
            S_LOOK: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_STALE;
                    n_out_index  = r_idx;
                    n_out_gen    = r_gen;
                    n_out_state  = '0;
                    case (r_op)
                        OP_ALLOC: begin
                            if (r_top == '0) begin
                                n_out_status = ST_FULL;
                            end else begin
                                slot_we      = 1'b1;
                                slot_wdata   = {1'b1, gen_new, r_val};
                                n_top        = r_top - CAP_W'(1);
                                n_used       = r_used + CAP_W'(1);
                                n_out_status = ST_OK;
                                n_out_index  = SIDX_W'(r_slot);
                                n_out_gen    = HGEN_W'(gen_new);
                                n_out_state  = r_val;
                            end
                        end
                        OP_RELEASE: begin
                            if (handle_ok) begin
                                slot_we      = 1'b1;
                                slot_wdata   = {1'b0, rd_gen, {STATE_W{1'b0}}};
                                stk_we       = 1'b1;
                                n_top        = r_top + CAP_W'(1);
                                n_used       = r_used - CAP_W'(1);
                                n_out_status = ST_OK;
                            end
                        end
                        OP_GET, OP_CHECK: begin
                            if (handle_ok) begin
                                n_out_status = ST_OK;
                                n_out_state  = rd_state;
                            end
                        end
                        OP_SET: begin
                            if (handle_ok) begin
                                slot_we      = 1'b1;
                                slot_wdata   = {1'b1, rd_gen, r_val};
                                n_out_status = ST_OK;
                                n_out_state  = r_val;
                            end
                        end
                        default: begin
                            n_out_status = ST_STALE;
                        end
                    endcase
                    n_out_count = n_used;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            n_cap      = cap_clamped;
            n_top      = cap_clamped;
            n_used     = '0;
            n_clr_addr = '0;
            n_state    = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_cap       <= CAP_RESET_V;
            r_top       <= CAP_RESET_V;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_cap       <= n_cap;
            r_top       <= n_top;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_idx        <= n_idx;
        r_gen        <= n_gen;
        r_val        <= n_val;
        r_slot       <= n_slot;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_gen    <= n_out_gen;
        r_out_state  <= n_out_state;
        r_out_count  <= n_out_count;
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_out_index      = r_out_index;
    assign o_out_generation = r_out_gen;
    assign o_out_state      = r_out_state;
    assign o_active_count   = r_out_count;

endmodule

/* design/gsa_ram.sv */
// ----------------------------------------------------------------------------
// gsa_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/gsa_checker.sv */
// ----------------------------------------------------------------------------
// gsa_checker
// Port-level checks of the generational slot allocator, bound to the top
// level.
// ----------------------------------------------------------------------------
module gsa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [gsa_pkg::STATUS_W-1:0]  o_status,
    input logic [gsa_pkg::SIDX_W-1:0]    o_out_index,
    input logic [gsa_pkg::HGEN_W-1:0]    o_out_generation,
    input logic [gsa_pkg::STATE_W-1:0]   o_out_state,
    input logic [gsa_pkg::CAP_W-1:0]     o_active_count,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready
);
    import gsa_pkg::*;

    // A stalled response holds its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_out_index) && $stable(o_out_generation)
            && $stable(o_out_state) && $stable(o_active_count))
        else $error("response changed while stalled");

    // A full table has at least one slot in use and returns no state.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> (o_active_count != '0)
            && (o_out_state == '0))
        else $error("full status with no slot in use");

    // A rejected handle returns no state.
    a_stale_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_STALE) |-> (o_out_state == '0))
        else $error("rejected handle returned state");

    // A capacity transfer starts the clearing pass, which blocks requests.
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_ready)
        else $error("request accepted during clearing pass");

endmodule

bind generational_slot_allocator_top gsa_checker u_gsa_checker (.*);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the generational slot allocator. A short table of
// directed requests runs first, then repeated reuse of a one-slot table, then
// random phases at several capacities and flow-control patterns.
// A behavioural copy of the slot table predicts every response but those of directed rows
// that give their own, and the responses are compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
    import gsa_pkg::*;

    localparam int NSLOT           = 256;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int LONG_HOLD       = 300;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int N_PHASES        = 8;
    localparam int REUSE_ROUNDS    = 24;

    localparam logic [OP_W-1:0] OP_UNDEF5 = 3'd5;
    localparam logic [OP_W-1:0] OP_UNDEF6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF7 = 3'd7;

    typedef enum int {FLOW_FREE, FLOW_TX_GAPS, FLOW_RX_STALLS, FLOW_BOTH} t_flow;
    typedef enum int {ROW_CAP, ROW_PRED, ROW_KNOWN} t_row_kind;

    typedef struct {
        t_status            status;
        logic [SIDX_W-1:0]  idx;
        logic [HGEN_W-1:0]  gen;
        logic [STATE_W-1:0] word;
        logic [CAP_W-1:0]   live;
    } t_resp;

    typedef struct {
        logic [SIDX_W-1:0] idx;
        logic [HGEN_W-1:0] gen;
    } t_handle;

    typedef struct {
        t_row_kind          kind;
        logic [OP_W-1:0]    op;
        logic [SIDX_W-1:0]  idx;
        logic [HGEN_W-1:0]  gen;
        logic [STATE_W-1:0] val;
        t_resp              want;
    } t_vec;

    logic                i_clk               = 1'b0;
    logic                i_rst_n             = 1'b0;
    logic                i_valid             = 1'b0;
    logic                o_ready;
    logic [OP_W-1:0]     i_op                = '0;
    logic [SIDX_W-1:0]   i_slot_index        = '0;
    logic [HGEN_W-1:0]   i_handle_generation = '0;
    logic [STATE_W-1:0]  i_state_value       = '0;
    logic                o_valid;
    logic                i_ready             = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [SIDX_W-1:0]   o_out_index;
    logic [HGEN_W-1:0]   o_out_generation;
    logic [STATE_W-1:0]  o_out_state;
    logic [CAP_W-1:0]    o_active_count;
    logic                i_cfg_valid         = 1'b0;
    logic                o_cfg_ready;
    logic [CAP_W-1:0]    i_cfg_capacity      = '0;

    generational_slot_allocator_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_op                (i_op),
        .i_slot_index        (i_slot_index),
        .i_handle_generation (i_handle_generation),
        .i_state_value       (i_state_value),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_out_index         (o_out_index),
        .o_out_generation    (o_out_generation),
        .o_out_state         (o_out_state),
        .o_active_count      (o_active_count),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_capacity      (i_cfg_capacity)
    );

    logic [SIDX_W-1:0]  free_stk  [NSLOT];
    logic [HGEN_W-1:0]  slot_gen  [NSLOT];
    bit                 slot_busy [NSLOT];
    logic [STATE_W-1:0] slot_word [NSLOT];
    int                 free_top;
    int                 slot_cap;
    int                 live_cnt;

    t_resp   awaited[$];
    t_handle live_handles[$];
    t_handle dead_handles[$];
    t_vec    directed[$];

    t_flow flow          = FLOW_FREE;
    int    hold_requests = 0;
    int    quiet_cycles  = 0;
    int    n_fail        = 0;
    int    n_sent        = 0;
    int    n_checked     = 0;
    int    n_caps        = 0;
    int    n_full        = 0;
    int    n_stale       = 0;

    function automatic void rebuild_table(int cap);
        slot_cap = cap;
        free_top = cap;
        live_cnt = 0;
        for (int i = 0; i < NSLOT; i++) begin
            slot_gen[i]  = '0;
            slot_busy[i] = 1'b0;
            slot_word[i] = '0;
            free_stk[i]  = (i < cap) ? SIDX_W'(cap - 1 - i) : '0;
        end
    endfunction

    function automatic t_resp apply_request(logic [OP_W-1:0] op, logic [SIDX_W-1:0] idx,
                                            logic [HGEN_W-1:0] gen, logic [STATE_W-1:0] val);
        t_resp             r;
        logic [SIDX_W-1:0] s;
        r.status = ST_STALE;
        r.idx    = idx;
        r.gen    = gen;
        r.word   = '0;
        if (op == OP_ALLOC) begin
            if (free_top == 0) begin
                r.status = ST_FULL;
            end else begin
                free_top--;
                s = free_stk[free_top];
                slot_gen[s] = slot_gen[s] + HGEN_W'(1);
                if (slot_gen[s] == '0) begin
                    slot_gen[s] = HGEN_W'(1);
                end
                slot_busy[s] = 1'b1;
                slot_word[s] = val;
                live_cnt++;
                r.status = ST_OK;
                r.idx    = s;
                r.gen    = slot_gen[s];
                r.word   = val;
            end
        end else if (op <= OP_CHECK && gen != '0 && idx < slot_cap && slot_busy[idx]
                     && slot_gen[idx] == gen) begin
            r.status = ST_OK;
            if (op == OP_RELEASE) begin
                slot_busy[idx] = 1'b0;
                slot_word[idx] = '0;
                if (free_top < NSLOT) begin
                    free_stk[free_top] = idx;
                    free_top++;
                end
                if (live_cnt > 0) begin
                    live_cnt--;
                end
            end else if (op == OP_SET) begin
                slot_word[idx] = val;
            end
            r.word = slot_word[idx];
        end
        r.live = CAP_W'(live_cnt);
        return r;
    endfunction

    function automatic void row(t_row_kind kind, logic [OP_W-1:0] op, logic [SIDX_W-1:0] idx,
                                logic [HGEN_W-1:0] gen, logic [STATE_W-1:0] val,
                                t_status st = ST_OK, logic [SIDX_W-1:0] oidx = '0,
                                logic [HGEN_W-1:0] ogen = '0, logic [STATE_W-1:0] oword = '0,
                                logic [CAP_W-1:0] live = '0);
        t_vec v;
        v.kind        = kind;
        v.op          = op;
        v.idx         = idx;
        v.gen         = gen;
        v.val         = val;
        v.want.status = st;
        v.want.idx    = oidx;
        v.want.gen    = ogen;
        v.want.word   = oword;
        v.want.live   = live;
        directed.insert(directed.size(), v);
    endfunction

    function automatic void retire(t_handle h);
        dead_handles.insert(dead_handles.size(), h);
        if (dead_handles.size() > 64) begin
            void'(dead_handles.pop_front());
        end
    endfunction

    function automatic bit tx_gap();
        if (flow == FLOW_TX_GAPS) return $urandom_range(99) < 51;
        if (flow == FLOW_BOTH) return $urandom_range(99) < 14;
        return 1'b0;
    endfunction

    function automatic bit rx_stall();
        if (flow == FLOW_RX_STALLS) return $urandom_range(99) < 51;
        if (flow == FLOW_BOTH) return $urandom_range(99) < 14;
        return 1'b0;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            n_fail++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // Called and returning at a falling edge; valid is left high after a transfer.
    task automatic issue(input logic [OP_W-1:0] op, input logic [SIDX_W-1:0] idx,
                         input logic [HGEN_W-1:0] gen, input logic [STATE_W-1:0] val,
                         input bit known, input t_resp want);
        t_resp   r;
        t_handle h;
        while (tx_gap()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid             <= 1'b1;
        i_op                <= op;
        i_slot_index        <= idx;
        i_handle_generation <= gen;
        i_state_value       <= val;
        do @(posedge i_clk); while (!o_ready);
        r = apply_request(op, idx, gen, val);
        if (known) begin
            awaited.insert(awaited.size(), want);
        end else begin
            awaited.insert(awaited.size(), r);
        end
        n_sent++;
        if (r.status == ST_FULL) begin
            n_full++;
        end else if (r.status == ST_STALE) begin
            n_stale++;
        end
        if (op == OP_ALLOC && r.status == ST_OK) begin
            h.idx = r.idx;
            h.gen = r.gen;
            live_handles.insert(live_handles.size(), h);
        end
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (awaited.size() > 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        int eff;
        settle();
        i_cfg_valid    <= 1'b1;
        i_cfg_capacity <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        eff = (v == 0) ? 1 : ((v > NSLOT) ? NSLOT : int'(v));
        rebuild_table(eff);
        while (live_handles.size() > 0) retire(live_handles.pop_front());
        n_caps++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        int                 pick;
        int                 k;
        t_handle            h;
        t_resp              none;
        logic [OP_W-1:0]    op;
        logic [SIDX_W-1:0]  idx;
        logic [HGEN_W-1:0]  gen;
        logic [STATE_W-1:0] val;
        pick = $urandom_range(99);
        val  = $urandom;
        idx  = SIDX_W'($urandom);
        gen  = HGEN_W'($urandom);
        op   = OP_ALLOC;
        if (pick < 30) begin
            op = OP_ALLOC;
        end else if (pick < 88 && live_handles.size() > 0) begin
            k   = $urandom_range(live_handles.size() - 1);
            h   = live_handles[k];
            idx = h.idx;
            gen = h.gen;
            if (pick < 50) begin
                op = OP_RELEASE;
                live_handles.delete(k);
                retire(h);
            end else if (pick < 65) begin
                op = OP_GET;
            end else if (pick < 80) begin
                op = OP_SET;
            end else begin
                op = OP_CHECK;
            end
        end else begin
            op = OP_W'($urandom_range(OP_UNDEF7));
            case ($urandom_range(3))
                0: gen = '0;
                1: begin
                    if (dead_handles.size() > 0) begin
                        h   = dead_handles[$urandom_range(dead_handles.size() - 1)];
                        idx = h.idx;
                        gen = h.gen;
                    end
                end
                2: begin
                    if (slot_cap < NSLOT) begin
                        idx = SIDX_W'($urandom_range(NSLOT - 1, slot_cap));
                    end
                end
                default: ;
            endcase
        end
        issue(op, idx, gen, val, 1'b0, none);
    endtask

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    initial begin : rx_side
        int hold_left;
        int seen;
        hold_left = 0;
        seen      = 0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != seen) begin
                seen      = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !rx_stall();
            end
        end
    end

    initial begin : result_check
        t_resp w;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (i_rst_n && o_valid && i_ready) begin
                if (awaited.size() == 0) begin
                    n_fail++;
                    $error("response with nothing outstanding: status %0d index %0d",
                           o_status, o_out_index);
                end else begin
                    w = awaited.pop_front();
                    n_checked++;
                    check_field("status", w.status, o_status);
                    check_field("out_index", w.idx, o_out_index);
                    check_field("out_generation", w.gen, o_out_generation);
                    check_field("out_state", w.word, o_out_state);
                    check_field("active_count", w.live, o_active_count);
                end
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Watchdog: no transfer for %0d cycles.", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        t_vec    v;
        t_resp   none;
        t_handle h;
        int      cap;
        rebuild_table(NSLOT);

        row(ROW_KNOWN, OP_GET, 8'h00, 16'h0000, 32'h0, ST_STALE, 8'h00, 16'h0000, 32'h0, 9'd0);
        row(ROW_KNOWN, OP_ALLOC, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
            ST_OK, 8'h00, 16'h0001, 32'hFFFF_FFFF, 9'd1);
        row(ROW_KNOWN, OP_ALLOC, 8'h00, 16'h0000, 32'h0, ST_OK, 8'h01, 16'h0001, 32'h0, 9'd2);
        row(ROW_KNOWN, OP_GET, 8'h00, 16'h0001, 32'h0,
            ST_OK, 8'h00, 16'h0001, 32'hFFFF_FFFF, 9'd2);
        row(ROW_KNOWN, OP_SET, 8'h01, 16'h0001, 32'hA5A5_5A5A,
            ST_OK, 8'h01, 16'h0001, 32'hA5A5_5A5A, 9'd2);
        row(ROW_KNOWN, OP_CHECK, 8'h01, 16'h0001, 32'h0,
            ST_OK, 8'h01, 16'h0001, 32'hA5A5_5A5A, 9'd2);
        row(ROW_KNOWN, OP_CHECK, 8'h01, 16'h0002, 32'h0, ST_STALE, 8'h01, 16'h0002, 32'h0, 9'd2);
        row(ROW_KNOWN, OP_GET, 8'hFF, 16'hFFFF, 32'h0, ST_STALE, 8'hFF, 16'hFFFF, 32'h0, 9'd2);
        row(ROW_KNOWN, OP_RELEASE, 8'h00, 16'h0001, 32'hFFFF_FFFF,
            ST_OK, 8'h00, 16'h0001, 32'h0, 9'd1);
        row(ROW_KNOWN, OP_RELEASE, 8'h00, 16'h0001, 32'h0, ST_STALE, 8'h00, 16'h0001, 32'h0, 9'd1);
        row(ROW_KNOWN, OP_ALLOC, 8'h00, 16'h0000, 32'h1234_5678,
            ST_OK, 8'h00, 16'h0002, 32'h1234_5678, 9'd2);
        row(ROW_KNOWN, OP_GET, 8'h00, 16'h0001, 32'h0, ST_STALE, 8'h00, 16'h0001, 32'h0, 9'd2);
        row(ROW_KNOWN, OP_UNDEF5, 8'h00, 16'h0002, 32'h0, ST_STALE, 8'h00, 16'h0002, 32'h0, 9'd2);
        row(ROW_PRED, OP_UNDEF6, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        row(ROW_PRED, OP_UNDEF7, 8'h01, 16'h0001, 32'h0);
        row(ROW_PRED, OP_SET, 8'h00, 16'h0002, 32'h0);
        row(ROW_CAP, OP_ALLOC, 8'h00, 16'h0000, 32'd1);
        row(ROW_KNOWN, OP_ALLOC, 8'h00, 16'h0000, 32'hDEAD_BEEF,
            ST_OK, 8'h00, 16'h0001, 32'hDEAD_BEEF, 9'd1);
        row(ROW_KNOWN, OP_ALLOC, 8'h55, 16'hAAAA, 32'h0, ST_FULL, 8'h55, 16'hAAAA, 32'h0, 9'd1);
        row(ROW_KNOWN, OP_GET, 8'h01, 16'h0001, 32'h0, ST_STALE, 8'h01, 16'h0001, 32'h0, 9'd1);
        row(ROW_KNOWN, OP_GET, 8'h00, 16'h0001, 32'h0,
            ST_OK, 8'h00, 16'h0001, 32'hDEAD_BEEF, 9'd1);
        row(ROW_CAP, OP_ALLOC, 8'h00, 16'h0000, 32'd0);
        row(ROW_KNOWN, OP_ALLOC, 8'h00, 16'h0000, 32'h0000_0001,
            ST_OK, 8'h00, 16'h0001, 32'h0000_0001, 9'd1);
        row(ROW_PRED, OP_RELEASE, 8'h00, 16'h0001, 32'h0);
        row(ROW_CAP, OP_ALLOC, 8'h00, 16'h0000, 32'd511);
        row(ROW_PRED, OP_GET, 8'hFF, 16'h0001, 32'h0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[n]) begin
            v = directed[n];
            if (v.kind == ROW_CAP) begin
                write_capacity(v.val[CAP_W-1:0]);
            end else begin
                issue(v.op, v.idx, v.gen, v.val, v.kind == ROW_KNOWN, v.want);
            end
        end

        // One slot, allocated and released over and over so its generation climbs.
        write_capacity(9'd1);
        repeat (REUSE_ROUNDS) begin
            issue(OP_ALLOC, SIDX_W'($urandom), HGEN_W'($urandom), $urandom, 1'b0, none);
            h = live_handles[$];
            live_handles.delete(live_handles.size() - 1);
            issue(OP_RELEASE, h.idx, h.gen, $urandom, 1'b0, none);
        end
        issue(OP_CHECK, 8'h00, 16'hFFFF, 32'h0, 1'b0, none);
        issue(OP_ALLOC, 8'h00, 16'h0000, $urandom, 1'b0, none);

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: cap = 4;
                1: cap = 1;
                2: cap = 17;
                3: cap = 300;
                4: cap = 2;
                5: cap = $urandom_range(3, 64);
                6: cap = 8;
                default: cap = 256;
            endcase
            write_capacity(CAP_W'(cap));
            flow = t_flow'(p % 4);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p == 4 && k == 20) begin
                    hold_requests++;
                end
                if (k == ITEMS_PER_PHASE / 2) begin
                    settle();
                end
                random_request();
            end
        end

        settle();
        repeat (10) @(negedge i_clk);
        $display("Run covered %0d requests, %0d responses checked, %0d capacity writes.",
                 n_sent, n_checked, n_caps);
        $display("Table-full answers: %0d, stale-handle answers: %0d, one-slot reuse rounds: %0d.",
                 n_full, n_stale, REUSE_ROUNDS);
        if (n_fail == 0 && awaited.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
